// ===== rtl/mst_pkg.sv =====
`default_nettype none

package mst_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int MAX_RESULTS   = 8;
  localparam int CNT_W         = 4;

  localparam logic [1:0] CMD_START_ONE = 2'd0;
  localparam logic [1:0] CMD_START_REP = 2'd1;
  localparam logic [1:0] CMD_STOP      = 2'd2;
  localparam logic [1:0] CMD_CHECK     = 2'd3;

  localparam logic [2:0] KIND_STARTED    = 3'd0;
  localparam logic [2:0] KIND_NO_FREE    = 3'd1;
  localparam logic [2:0] KIND_STOPPED    = 3'd2;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd3;
  localparam logic [2:0] KIND_FIRED      = 3'd4;
  localparam logic [2:0] KIND_NONE_FIRED = 3'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  handle;
    logic [31:0] delay;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] slot;
    logic [7:0] fired_handle;
    logic       last;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/mst_slot_mem.sv =====
`default_nettype none

module mst_slot_mem #(
  parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF,
  parameter int IDX_W     = 3
) (
  input  wire logic             clk,
  input  wire logic             wr_all_en,
  input  wire logic             wr_start_en,
  input  wire logic [IDX_W-1:0] wr_addr,
  input  wire logic [7:0]       wr_owner,
  input  wire logic [31:0]      wr_period,
  input  wire logic [31:0]      wr_start,
  input  wire logic [IDX_W-1:0] rd_addr,
  output logic [7:0]            rd_owner,
  output logic [31:0]           rd_period,
  output logic [31:0]           rd_start
);

  logic [39:0] owner_period_mem [NUM_SLOTS];
  logic [31:0] start_mem [NUM_SLOTS];
  logic [39:0] rd_op_r;
  logic [31:0] rd_start_r;

  always_ff @(posedge clk) begin
    if (wr_all_en) begin
      owner_period_mem[wr_addr] <= {wr_owner, wr_period};
    end
    if (wr_all_en || wr_start_en) begin
      start_mem[wr_addr] <= wr_start;
    end
    rd_op_r    <= owner_period_mem[rd_addr];
    rd_start_r <= start_mem[rd_addr];
  end

  assign rd_owner  = rd_op_r[39:32];
  assign rd_period = rd_op_r[31:0];
  assign rd_start  = rd_start_r;

endmodule

`default_nettype wire

// ===== rtl/multi_slot_software_timer_top.sv =====
// A start or stop result is produced by the slot that settles it, and the scan ends there;
// a check scans every slot and reports the results that it finds.
// Items are taken one at a time; the slot scan reads one slot and runs the shared expiry
// compare per cycle, and a waiting result pauses it.
// Reset (synchronous, active low) clears all active and periodic flags and the handshakes.
`default_nettype none

module multi_slot_software_timer_top #(
  parameter int NUM_SLOTS = mst_pkg::NUM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mst_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output mst_pkg::out_item_t     out_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  mst_pkg::state_t               state_r, state_nxt;
  logic [IDX_W-1:0]              idx_r, idx_nxt;
  logic [NUM_SLOTS-1:0]          active_r, active_nxt;
  logic [NUM_SLOTS-1:0]          periodic_r, periodic_nxt;
  logic [mst_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  mst_pkg::in_item_t             item_r, item_nxt;
  logic                          pend_valid_r, pend_valid_nxt;
  mst_pkg::out_item_t            pend_r, pend_nxt;
  logic                          out_valid_r, out_valid_nxt;
  mst_pkg::out_item_t            out_data_r, out_data_nxt;

  logic                          wr_all_en;
  logic                          wr_start_en;
  logic [7:0]                    rd_owner;
  logic [31:0]                   rd_period;
  logic [31:0]                   rd_start;
  logic [31:0]                   elapsed;
  logic                          expired;
  logic                          out_free;
  logic                          last_idx;
  logic                          report;
  mst_pkg::out_item_t            cur_res;

  mst_slot_mem #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_slot_mem (
    .clk         (clk),
    .wr_all_en   (wr_all_en),
    .wr_start_en (wr_start_en),
    .wr_addr     (idx_r),
    .wr_owner    (item_r.handle),
    .wr_period   (item_r.delay),
    .wr_start    (item_r.now),
    .rd_addr     (idx_nxt),
    .rd_owner    (rd_owner),
    .rd_period   (rd_period),
    .rd_start    (rd_start)
  );

  assign elapsed  = item_r.now - rd_start;
  assign expired  = active_r[idx_r] && (elapsed >= rd_period);
  assign out_free = !out_valid_r || out_ready;
  assign last_idx = (idx_r == IDX_W'(NUM_SLOTS - 1));
  assign report   = expired && (rd_owner != 8'd0) &&
                    (cnt_r < mst_pkg::CNT_W'(mst_pkg::MAX_RESULTS));

  assign in_ready  = (state_r == mst_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    active_nxt     = active_r;
    periodic_nxt   = periodic_r;
    cnt_nxt        = cnt_r;
    item_nxt       = item_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    wr_all_en      = 1'b0;
    wr_start_en    = 1'b0;
    cur_res        = '{kind: mst_pkg::KIND_FIRED, slot: 3'(idx_r),
                       fired_handle: rd_owner, last: 1'b0};
    case (state_r)
      mst_pkg::ST_IDLE: begin
        idx_nxt = '0;
        if (in_valid) begin
          item_nxt       = in_data;
          cnt_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = mst_pkg::ST_SCAN;
        end
      end
      mst_pkg::ST_SCAN: begin
        if (out_free) begin
          idx_nxt = idx_r + IDX_W'(1);
          case (item_r.cmd)
            mst_pkg::CMD_START_ONE, mst_pkg::CMD_START_REP: begin
              if (!active_r[idx_r]) begin
                wr_all_en             = 1'b1;
                active_nxt[idx_r]     = 1'b1;
                periodic_nxt[idx_r]   = (item_r.cmd == mst_pkg::CMD_START_REP);
                out_valid_nxt         = 1'b1;
                out_data_nxt          = '{kind: mst_pkg::KIND_STARTED, slot: 3'(idx_r),
                                          fired_handle: item_r.handle, last: 1'b1};
                state_nxt             = mst_pkg::ST_IDLE;
              end else if (last_idx) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: mst_pkg::KIND_NO_FREE, slot: 3'd0,
                                  fired_handle: 8'd0, last: 1'b1};
                state_nxt     = mst_pkg::ST_IDLE;
              end
            end
            mst_pkg::CMD_STOP: begin
              if (active_r[idx_r] && (rd_owner == item_r.handle)) begin
                active_nxt[idx_r] = 1'b0;
                out_valid_nxt     = 1'b1;
                out_data_nxt      = '{kind: mst_pkg::KIND_STOPPED, slot: 3'(idx_r),
                                      fired_handle: item_r.handle, last: 1'b1};
                state_nxt         = mst_pkg::ST_IDLE;
              end else if (last_idx) begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '{kind: mst_pkg::KIND_NOT_FOUND, slot: 3'd0,
                                  fired_handle: 8'd0, last: 1'b1};
                state_nxt     = mst_pkg::ST_IDLE;
              end
            end
            default: begin
              if (expired) begin
                if (periodic_r[idx_r]) begin
                  wr_start_en = 1'b1;
                end else begin
                  active_nxt[idx_r] = 1'b0;
                end
              end
              if (report) begin
                cnt_nxt        = cnt_r + mst_pkg::CNT_W'(1);
                pend_valid_nxt = 1'b1;
                pend_nxt       = cur_res;
                if (pend_valid_r) begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = pend_r;
                end
              end
              if (last_idx) begin
                if (report || pend_valid_r) begin
                  state_nxt = mst_pkg::ST_FLUSH;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_data_nxt  = '{kind: mst_pkg::KIND_NONE_FIRED, slot: 3'd0,
                                    fired_handle: 8'd0, last: 1'b1};
                  state_nxt     = mst_pkg::ST_IDLE;
                end
              end
            end
          endcase
        end
      end
      mst_pkg::ST_FLUSH: begin
        idx_nxt = '0;
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_data_nxt      = pend_r;
          out_data_nxt.last = 1'b1;
          pend_valid_nxt    = 1'b0;
          state_nxt         = mst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= mst_pkg::ST_IDLE;
      idx_r        <= '0;
      active_r     <= '0;
      periodic_r   <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      idx_r        <= idx_nxt;
      active_r     <= active_nxt;
      periodic_r   <= periodic_nxt;
      cnt_r        <= cnt_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    pend_r     <= pend_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
